>>> hdl/sarp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sarp_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int OPC_W    = 3;
    localparam int STAT_W   = 2;
    localparam int ECOUNT_W = 7;

    // Largest value the reported entry count can carry
    localparam int COUNT_MAX = 127;

    // Operation codes
    localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OPC_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OPC_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OPC_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [IP_W-1:0]  ip_address;
        logic [MAC_W-1:0] mac_address;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [MAC_W-1:0]    found_mac;
        logic [ECOUNT_W-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_entry;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic sample;   // latch compare flags against the incoming key
        logic insert;   // open a slot at the insert point, shift right
        logic remove;   // close the first matching slot, shift left
        logic update;   // overwrite MAC of the first matching slot
        logic clear;    // drop every entry
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hdl/sarp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sarp_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sarp_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [sarp_pkg::IP_W-1:0] i_cmp_ip,
    input  wire sarp_pkg::t_entry     i_new,
    input  wire sarp_pkg::t_entry     i_left,
    input  wire sarp_pkg::t_entry     i_right,
    input  wire logic                 i_prev_lt,
    output sarp_pkg::t_entry          o_entry,
    output logic                      o_lt,
    output logic                      o_first
);

    logic                        r_valid;
    logic [sarp_pkg::IP_W-1:0]   r_ip;
    logic [sarp_pkg::MAC_W-1:0]  r_mac;
    logic                        r_lt;
    logic                        r_eq;

    assign o_entry = '{valid: r_valid, ip: r_ip, mac: r_mac};
    assign o_lt    = r_lt;
    // first match: equal here, and the neighbour below sorts lower (or none)
    assign o_first = r_eq && i_prev_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctrl.sample) begin
                r_lt <= r_valid && (r_ip < i_cmp_ip);
                r_eq <= r_valid && (r_ip == i_cmp_ip);
            end
            priority if (i_ctrl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctrl.insert && !r_lt) begin
                r_valid <= i_prev_lt ? 1'b1 : i_left.valid;
            end else if (i_ctrl.remove && !r_lt) begin
                r_valid <= i_right.valid;
            end else begin
                // hold
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.insert && !r_lt) begin
            r_ip  <= i_prev_lt ? i_new.ip  : i_left.ip;
            r_mac <= i_prev_lt ? i_new.mac : i_left.mac;
        end else if (i_ctrl.remove && !r_lt) begin
            r_ip  <= i_right.ip;
            r_mac <= i_right.mac;
        end else if (i_ctrl.update && o_first) begin
            r_mac <= i_new.mac;
        end else begin
            // hold
        end
    end

endmodule

`default_nettype wire

>>> hdl/sorted_arp_table.sv
`timescale 1ns / 1ps
// Sequence: a word is accepted and its compare flags latched; it is then applied
//   and the result register loaded once that register is empty or being read.
// Flow: a new word is accepted only after the previous one has been applied,
//   limited by the compare-then-shift sequence through the cell row.
// Reset: synchronous, active low; empties the table (count zero, all valid
//   bits clear) at once, no sweep; entry payloads are not cleared.
`default_nettype none

module sorted_arp_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sarp_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output sarp_pkg::t_out_word      o_out_word
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer state: one word held between acceptance and apply
    logic                              r_busy;
    logic [sarp_pkg::OPC_W-1:0]        r_op;
    logic [sarp_pkg::IP_W-1:0]         r_ip;
    logic [sarp_pkg::MAC_W-1:0]        r_mac;
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;

    // Output register
    logic                              r_out_valid;
    sarp_pkg::t_out_word               r_out;
    sarp_pkg::t_out_word               n_out;

    logic                              w_accept;
    logic                              w_apply;
    logic                              w_full;
    logic                              w_hit;
    sarp_pkg::t_cell_ctrl              w_ctrl;
    sarp_pkg::t_entry                  w_new;
    logic [sarp_pkg::MAC_W-1:0]        w_hit_mac;

    // Cell row wiring
    sarp_pkg::t_entry                  w_entry [TABLE_DEPTH];
    sarp_pkg::t_entry                  w_left  [TABLE_DEPTH];
    sarp_pkg::t_entry                  w_right [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]            w_lt;
    logic [TABLE_DEPTH-1:0]            w_prev_lt;
    logic [TABLE_DEPTH-1:0]            w_first;
    logic [TABLE_DEPTH-1:0]            w_valid_vec;

    // Handshake: take a word only when nothing is in flight; the output
    // register lets a new word in while a result still waits.
    assign o_in_ready  = !r_busy;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_apply     = r_busy && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_hit  = |w_first;
    assign w_new  = '{valid: 1'b1, ip: r_ip, mac: r_mac};

    // Broadcast control: compare flags are latched on acceptance, the row
    // then shifts or writes during the apply cycle.
    always_comb begin
        w_ctrl.sample = w_accept;
        w_ctrl.insert = w_apply && (r_op == sarp_pkg::OP_INSERT) && !w_full;
        w_ctrl.remove = w_apply && (r_op == sarp_pkg::OP_DELETE) && w_hit;
        w_ctrl.update = w_apply && (r_op == sarp_pkg::OP_UPDATE);
        w_ctrl.clear  = w_apply && (r_op == sarp_pkg::OP_CLEAR);
    end

    // Neighbour links: the bottom cell sees an empty left neighbour that
    // sorts below everything, the top cell an empty right neighbour.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_bottom
            assign w_left[g]    = '0;
            assign w_prev_lt[g] = 1'b1;
        end else begin : g_inner_l
            assign w_left[g]    = w_entry[g-1];
            assign w_prev_lt[g] = w_lt[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_top
            assign w_right[g] = '0;
        end else begin : g_inner_r
            assign w_right[g] = w_entry[g+1];
        end

        sarp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_cmp_ip  (i_in_word.ip_address),
            .i_new     (w_new),
            .i_left    (w_left[g]),
            .i_right   (w_right[g]),
            .i_prev_lt (w_prev_lt[g]),
            .o_entry   (w_entry[g]),
            .o_lt      (w_lt[g]),
            .o_first   (w_first[g])
        );

        assign w_valid_vec[g] = w_entry[g].valid;
    end

    // Select the MAC of the single first-match cell by an AND-OR tree
    always_comb begin
        w_hit_mac = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_hit_mac = w_hit_mac | (w_entry[k].mac & {sarp_pkg::MAC_W{w_first[k]}});
        end
    end

    // Result and new count
    always_comb begin
        n_count         = r_count;
        n_out.status    = sarp_pkg::ST_DONE;
        n_out.found_mac = '0;
        unique case (r_op)
            sarp_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_out.status = sarp_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            sarp_pkg::OP_LOOKUP: begin
                if (w_hit) begin
                    n_out.found_mac = w_hit_mac;
                end else begin
                    n_out.status = sarp_pkg::ST_MISSING;
                end
            end
            sarp_pkg::OP_DELETE: begin
                if (w_hit) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_out.status = sarp_pkg::ST_MISSING;
                end
            end
            sarp_pkg::OP_UPDATE: begin
                if (!w_hit) begin
                    n_out.status = sarp_pkg::ST_MISSING;
                end
            end
            sarp_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused codes: no operation
            end
        endcase
        // saturate the reported count for very deep tables
        if (32'(n_count) > 32'(sarp_pkg::COUNT_MAX)) begin
            n_out.entry_count = sarp_pkg::ECOUNT_W'(sarp_pkg::COUNT_MAX);
        end else begin
            n_out.entry_count = sarp_pkg::ECOUNT_W'(n_count);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_apply) begin
                r_busy <= 1'b0;
            end
            if (w_apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the accepted word, load the result on apply
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in_word.opcode;
            r_ip  <= i_in_word.ip_address;
            r_mac <= i_in_word.mac_address;
        end
        if (w_apply) begin
            r_out <= n_out;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= TABLE_DEPTH)
        else $error("entry count beyond table depth");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_count))
        else $error("valid cells disagree with entry count");

    a_single_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(w_first))
        else $error("more than one first-match cell");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.insert |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |=> (o_out_valid && !r_busy))
        else $error("applied word produced no result");

endmodule

`default_nettype wire

>>> test/sorted_arp_table_checker.sv
`timescale 1ns / 1ps

module sorted_arp_table_checker
    import sarp_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_word i_out_word,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_result_count,
    output int             o_full_count,
    output int             o_hit_count
);

    // Shadow copy of the table, packed in slots 0..arp_count-1
    logic [IP_W-1:0]  arp_ip  [TABLE_DEPTH];
    logic [MAC_W-1:0] arp_mac [TABLE_DEPTH];
    int               arp_count;

    t_out_word        pending_replies[$];
    int               fail_count;
    int               result_count;
    int               full_count;
    int               hit_count;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending_replies.size();
    assign o_result_count = result_count;
    assign o_full_count   = full_count;
    assign o_hit_count    = hit_count;

    initial begin
        arp_count    = 0;
        fail_count   = 0;
        result_count = 0;
        full_count   = 0;
        hit_count    = 0;
    end

    function automatic int first_hit(input logic [IP_W-1:0] ip);
        for (int i = 0; i < arp_count; i++) begin
            if (arp_ip[i] == ip) return i;
        end
        return -1;
    endfunction

    // Apply one operation to the shadow table and return the reply it should give
    function automatic t_out_word apply_op(input t_in_word w);
        t_out_word r;
        int        pos;
        r.status    = ST_DONE;
        r.found_mac = '0;
        case (w.opcode)
            OP_INSERT: begin
                if (arp_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                    full_count++;
                end else begin
                    pos = 0;
                    while (pos < arp_count && arp_ip[pos] < w.ip_address) pos++;
                    for (int i = arp_count; i > pos; i--) begin
                        arp_ip[i]  = arp_ip[i-1];
                        arp_mac[i] = arp_mac[i-1];
                    end
                    arp_ip[pos]  = w.ip_address;
                    arp_mac[pos] = w.mac_address;
                    arp_count++;
                end
            end
            OP_LOOKUP: begin
                pos = first_hit(w.ip_address);
                if (pos < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    r.found_mac = arp_mac[pos];
                    hit_count++;
                end
            end
            OP_DELETE: begin
                pos = first_hit(w.ip_address);
                if (pos < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    for (int i = pos; i + 1 < arp_count; i++) begin
                        arp_ip[i]  = arp_ip[i+1];
                        arp_mac[i] = arp_mac[i+1];
                    end
                    arp_count--;
                end
            end
            OP_UPDATE: begin
                pos = first_hit(w.ip_address);
                if (pos < 0) r.status = ST_MISSING;
                else arp_mac[pos] = w.mac_address;
            end
            OP_CLEAR: arp_count = 0;
            default: ;
        endcase
        r.entry_count = (arp_count > COUNT_MAX) ? ECOUNT_W'(COUNT_MAX) : ECOUNT_W'(arp_count);
        return r;
    endfunction

    task automatic check_reply(input t_out_word got);
        t_out_word want;
        if (pending_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: reply with nothing outstanding: status %0d mac %h count %0d",
                         $realtime, got.status, got.found_mac, got.entry_count);
        end else begin
            want = pending_replies.pop_front();
            result_count++;
            if (got.status !== want.status || got.found_mac !== want.found_mac ||
                got.entry_count !== want.entry_count) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: reply %0d: status %0d/%0d mac %h/%h count %0d/%0d (exp/got)",
                             $realtime, result_count, want.status, got.status,
                             want.found_mac, got.found_mac, want.entry_count, got.entry_count);
            end
        end
    endtask

    // Check replies before queueing new predictions: a word accepted this edge
    // can never be answered on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            arp_count = 0;
            pending_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_reply(i_out_word);
            if (i_in_valid && i_in_ready) pending_replies.push_back(apply_op(i_in_word));
        end
    end

endmodule

>>> test/tb_sorted_arp_table.sv
`timescale 1ns / 1ps

module tb_sorted_arp_table;
    import sarp_pkg::*;

    localparam int DEPTH       = 64;
    localparam int N_RANDOM    = 830;   // random words after the directed opening
    localparam int QUIET_TAIL  = 120;   // final words sent with no idling
    localparam int CYCLE_LIMIT = 200000;

    // Opcodes the block ignores
    localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;

    // Operation mix of one random round
    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_PROBE, MIX_ANY } mix_mode_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b1;
    t_out_word out_word;

    logic      quiet     = 1'b0;
    int        stall_left = 0;
    int        words_sent = 0;
    int        cycle_count = 0;
    int        fail_count;
    int        pending;
    int        result_count;
    int        full_count;
    int        hit_count;

    logic [IP_W-1:0] ip_pool [16];

    always #5 clk = ~clk;

    sorted_arp_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    sorted_arp_table_checker #(
        .TABLE_DEPTH (DEPTH)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_word      (in_word),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_word     (out_word),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_full_count   (full_count),
        .o_hit_count    (hit_count)
    );

    // Abandon the run if it hangs; the limit is many times the slowest legal run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d replies outstanding",
                     cycle_count, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // Back-pressure on the reply side: drop ready in random bursts, and start
    // no new burst during the quiet tail
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[MAC_W-1:0];
    endfunction

    // Mostly reuse a small set of addresses so that hits and duplicates are common
    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return ip_pool[$urandom_range(0, 15)];
    endfunction

    function automatic logic [OPC_W-1:0] pick_op(input mix_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MIX_FILL: begin
                if (r < 75) return OP_INSERT;
                if (r < 85) return OP_LOOKUP;
                if (r < 92) return OP_UPDATE;
                return OP_DELETE;
            end
            MIX_DRAIN: begin
                if (r < 60) return OP_DELETE;
                if (r < 75) return OP_LOOKUP;
                if (r < 85) return OP_UPDATE;
                if (r < 95) return OP_INSERT;
                return OP_SPARE_LO + OPC_W'($urandom_range(0, 2));
            end
            MIX_PROBE: begin
                if (r < 45) return OP_LOOKUP;
                if (r < 75) return OP_UPDATE;
                if (r < 85) return OP_INSERT;
                if (r < 95) return OP_DELETE;
                return OP_SPARE_LO + OPC_W'($urandom_range(0, 2));
            end
            default: begin
                if (r < 30) return OP_INSERT;
                if (r < 55) return OP_LOOKUP;
                if (r < 75) return OP_DELETE;
                if (r < 90) return OP_UPDATE;
                if (r < 93) return OP_CLEAR;
                return OP_SPARE_LO + OPC_W'($urandom_range(0, 2));
            end
        endcase
    endfunction

    // Offer one word from a falling edge, hold it until accepted, return on
    // the next falling edge with valid still high; a random gap beforehand
    // lowers valid first
    task automatic issue(input logic [OPC_W-1:0] op, input logic [IP_W-1:0] ip,
                         input logic [MAC_W-1:0] mac);
        t_in_word w;
        w.opcode      = op;
        w.ip_address  = ip;
        w.mac_address = mac;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    initial begin
        mix_mode_t mode;

        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        ip_pool[0]  = '0;
        ip_pool[15] = '1;

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: clear still succeeds, every search misses
        issue(OP_CLEAR,  32'h0000_0000, '0);
        issue(OP_LOOKUP, 32'h0000_0000, '0);
        issue(OP_DELETE, 32'h0000_0000, '0);
        issue(OP_UPDATE, 32'h0000_0000, '1);
        // Extreme keys and MACs, then a duplicate that must land ahead
        issue(OP_INSERT, 32'hFFFF_FFFF, '1);
        issue(OP_INSERT, 32'h0000_0000, '0);
        issue(OP_INSERT, 32'h0A00_0001, 48'h0000_0000_0001);
        issue(OP_INSERT, 32'h0A00_0001, 48'h0000_0000_0002);
        issue(OP_LOOKUP, 32'h0A00_0001, '0);
        issue(OP_UPDATE, 32'h0A00_0001, 48'hAAAA_5555_AAAA);
        issue(OP_LOOKUP, 32'h0A00_0001, '0);
        issue(OP_DELETE, 32'h0A00_0001, '0);
        issue(OP_LOOKUP, 32'h0A00_0001, '0);
        issue(OP_LOOKUP, 32'hFFFF_FFFF, '0);
        issue(OP_LOOKUP, 32'h0000_0000, '1);
        // Misses on a populated table
        issue(OP_LOOKUP, 32'h0A00_0002, '0);
        issue(OP_UPDATE, 32'h0A00_0002, '1);
        issue(OP_DELETE, 32'h0A00_0002, '0);
        // Ignored opcodes with every payload bit set
        issue(OP_SPARE_LO,        '1, '1);
        issue(OP_SPARE_LO + 3'd1, '1, '1);
        issue(OP_SPARE_LO + 3'd2, '1, '1);
        issue(OP_DELETE, 32'hFFFF_FFFF, '0);
        issue(OP_CLEAR,  32'hFFFF_FFFF, '1);
        issue(OP_LOOKUP, 32'h0000_0000, '0);

        // Overfill first so that refused inserts are certain, then rounds of
        // mixed operations biased towards filling, draining or probing, or with no bias
        repeat (70) issue(OP_INSERT, pick_ip(), rand_mac());
        while (words_sent < 24 + N_RANDOM) begin
            mode = mix_mode_t'($urandom_range(0, 3));
            repeat (40) begin
                if (words_sent < 24 + N_RANDOM) begin
                    if (words_sent >= 24 + N_RANDOM - QUIET_TAIL) quiet <= 1'b1;
                    issue(pick_op(mode), pick_ip(), rand_mac());
                end
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding replies, then allow the pipeline to settle
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d operation words and checked %0d replies,", words_sent, result_count);
        $display("including %0d refused inserts on a full table and %0d lookup hits.",
                 full_count, hit_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sorted_arp_table.f
hdl/sarp_pkg.sv
hdl/sarp_cell.sv
hdl/sorted_arp_table.sv
test/sorted_arp_table_checker.sv
test/tb_sorted_arp_table.sv
